### src/fgrp_pkg.sv
// ----------------------------------------------------------------------------
// fgrp_pkg
// shared types and constants of the glyph record parser
// ----------------------------------------------------------------------------
package fgrp_pkg;

    localparam int unsigned FILE_HEADER_LEN  = 4;
    localparam int unsigned BLOCK_HEADER_LEN = 5;
    localparam int unsigned RECORD_LEN       = 20;
    localparam logic [7:0]  GLYPH_BLOCK_ID   = 8'd4;

    localparam int unsigned HDR_CNT_W = $clog2(BLOCK_HEADER_LEN);
    localparam int unsigned REC_IDX_W = $clog2(RECORD_LEN);

    typedef enum logic [2:0] {
        PH_FILE_HDR  = 3'b001,
        PH_BLOCK_HDR = 3'b010,
        PH_BODY      = 3'b100
    } phase_t;

    typedef struct packed {
        logic [31:0] glyph_code;
        logic [15:0] atlas_x;
        logic [15:0] atlas_y;
        logic [15:0] glyph_width;
        logic [15:0] glyph_height;
        logic [15:0] draw_offset_x;
        logic [15:0] draw_offset_y;
        logic [15:0] advance;
        logic [7:0]  page_index;
        logic [7:0]  channel_mask;
    } glyph_t;

endpackage

### src/fgrp_byte_if.sv
// ----------------------------------------------------------------------------
// fgrp_byte_if
// byte stream channel into the parser
// ----------------------------------------------------------------------------
interface fgrp_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);

endinterface

### src/fgrp_glyph_if.sv
// ----------------------------------------------------------------------------
// fgrp_glyph_if
// glyph result channel out of the parser
// ----------------------------------------------------------------------------
interface fgrp_glyph_if;

    logic        valid;
    logic        ready;
    logic [31:0] glyph_code;
    logic [15:0] atlas_x;
    logic [15:0] atlas_y;
    logic [15:0] glyph_width;
    logic [15:0] glyph_height;
    logic [15:0] draw_offset_x;
    logic [15:0] draw_offset_y;
    logic [15:0] advance;
    logic [7:0]  page_index;
    logic [7:0]  channel_mask;

    modport source (
        output valid, output glyph_code, output atlas_x, output atlas_y,
        output glyph_width, output glyph_height, output draw_offset_x,
        output draw_offset_y, output advance, output page_index,
        output channel_mask, input ready
    );
    modport sink (
        input valid, input glyph_code, input atlas_x, input atlas_y,
        input glyph_width, input glyph_height, input draw_offset_x,
        input draw_offset_y, input advance, input page_index,
        input channel_mask, output ready
    );

endinterface

### src/fgrp_record_buf.sv
// ----------------------------------------------------------------------------
// fgrp_record_buf
// record byte shift register and little-endian glyph unpack
// ----------------------------------------------------------------------------
module fgrp_record_buf (
    input  logic            clk,
    input  logic            shift_en,
    input  logic [7:0]      data_byte,
    output fgrp_pkg::glyph_t glyph
);

    localparam int unsigned Depth = fgrp_pkg::RECORD_LEN - 1;

    logic [7:0] rec_reg  [Depth];
    logic [7:0] rec_next [Depth];

    // shift in at the top so the oldest byte ends up in entry 0
    always_comb
    begin
        for (int i = 0; i < Depth - 1; i++)
        begin
            rec_next[i] = rec_reg[i + 1];
        end
        rec_next[Depth - 1] = data_byte;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            rec_reg <= rec_next;
        end
    end

    always_comb
    begin
        glyph.glyph_code    = {rec_reg[3], rec_reg[2], rec_reg[1], rec_reg[0]};
        glyph.atlas_x       = {rec_reg[5], rec_reg[4]};
        glyph.atlas_y       = {rec_reg[7], rec_reg[6]};
        glyph.glyph_width   = {rec_reg[9], rec_reg[8]};
        glyph.glyph_height  = {rec_reg[11], rec_reg[10]};
        glyph.draw_offset_x = {rec_reg[13], rec_reg[12]};
        glyph.draw_offset_y = {rec_reg[15], rec_reg[14]};
        glyph.advance       = {rec_reg[17], rec_reg[16]};
        glyph.page_index    = rec_reg[18];
        glyph.channel_mask  = data_byte;
    end

endmodule

### src/font_glyph_record_parser_unit.sv
// ----------------------------------------------------------------------------
// font_glyph_record_parser_unit
// parses a binary bitmap-font stream and emits one transaction per glyph record
//
//   channel   dir   payload                                   use
//   bytes     in    data_byte, start_of_file                  font file bytes
//   glyphs    out   glyph_code .. channel_mask                glyph records
//
// one byte per cycle when not held off as below; a glyph appears in the result
// register the cycle after the byte that completes its record
// rst_n clears the parse state; start_of_file restarts the parse on any byte
// a stalled glyph holds off any byte offered at the last position of a record
// ----------------------------------------------------------------------------
module font_glyph_record_parser_unit (
    input  logic  clk,
    input  logic  rst_n,
    fgrp_byte_if.sink    bytes,
    fgrp_glyph_if.source glyphs
);

    localparam int unsigned HdrW = fgrp_pkg::HDR_CNT_W;
    localparam int unsigned IdxW = fgrp_pkg::REC_IDX_W;

    fgrp_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [HdrW-1:0]  hdr_cnt_reg, hdr_cnt_next, hdr_cnt_eff;
    logic [31:0]      body_left_reg, body_left_next, body_left_eff;
    logic             glyph_blk_reg, glyph_blk_next, glyph_blk_eff;
    logic [IdxW-1:0]  rec_idx_reg, rec_idx_next, rec_idx_eff;
    logic             out_valid_reg, out_valid_next;
    fgrp_pkg::glyph_t out_reg;
    fgrp_pkg::glyph_t glyph_unpacked;

    logic        accept;
    logic        last_possible;
    logic        produce;
    logic        shift_en;
    logic [31:0] size_shifted;

    assign last_possible = (phase_reg == fgrp_pkg::PH_BODY) && glyph_blk_reg &&
                           (rec_idx_reg == IdxW'(fgrp_pkg::RECORD_LEN - 1));
    assign bytes.ready   = !out_valid_reg || glyphs.ready || !last_possible;
    assign accept        = bytes.valid && bytes.ready;

    always_comb
    begin
        if (bytes.start_of_file)
        begin
            phase_eff     = fgrp_pkg::PH_FILE_HDR;
            hdr_cnt_eff   = '0;
            body_left_eff = '0;
            glyph_blk_eff = 1'b0;
            rec_idx_eff   = '0;
        end
        else
        begin
            phase_eff     = phase_reg;
            hdr_cnt_eff   = hdr_cnt_reg;
            body_left_eff = body_left_reg;
            glyph_blk_eff = glyph_blk_reg;
            rec_idx_eff   = rec_idx_reg;
        end
    end

    // size bytes arrive least significant first
    assign size_shifted = {bytes.data_byte, body_left_eff[31:8]};

    always_comb
    begin
        phase_next     = phase_eff;
        hdr_cnt_next   = hdr_cnt_eff;
        body_left_next = body_left_eff;
        glyph_blk_next = glyph_blk_eff;
        rec_idx_next   = rec_idx_eff;
        produce        = 1'b0;
        shift_en       = 1'b0;

        case (phase_eff)
            fgrp_pkg::PH_BLOCK_HDR:
            begin
                if (hdr_cnt_eff == '0)
                begin
                    glyph_blk_next = (bytes.data_byte == fgrp_pkg::GLYPH_BLOCK_ID);
                end
                body_left_next = size_shifted;
                if (hdr_cnt_eff == HdrW'(fgrp_pkg::BLOCK_HEADER_LEN - 1))
                begin
                    hdr_cnt_next = '0;
                    rec_idx_next = '0;
                    if (size_shifted != '0)
                    begin
                        phase_next = fgrp_pkg::PH_BODY;
                    end
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_eff + HdrW'(1);
                end
            end
            fgrp_pkg::PH_BODY:
            begin
                if (glyph_blk_eff)
                begin
                    if (rec_idx_eff == IdxW'(fgrp_pkg::RECORD_LEN - 1))
                    begin
                        produce      = 1'b1;
                        rec_idx_next = '0;
                    end
                    else
                    begin
                        shift_en     = 1'b1;
                        rec_idx_next = rec_idx_eff + IdxW'(1);
                    end
                end
                body_left_next = body_left_eff - 32'd1;
                if (body_left_eff == 32'd1)
                begin
                    phase_next   = fgrp_pkg::PH_BLOCK_HDR;
                    hdr_cnt_next = '0;
                    rec_idx_next = '0;
                end
            end
            default:
            begin
                if (hdr_cnt_eff == HdrW'(fgrp_pkg::FILE_HEADER_LEN - 1))
                begin
                    phase_next   = fgrp_pkg::PH_BLOCK_HDR;
                    hdr_cnt_next = '0;
                end
                else
                begin
                    hdr_cnt_next = hdr_cnt_eff + HdrW'(1);
                end
            end
        endcase
    end

    fgrp_record_buf u_record_buf (
        .clk       (clk),
        .shift_en  (accept && shift_en),
        .data_byte (bytes.data_byte),
        .glyph     (glyph_unpacked)
    );

    always_comb
    begin
        if (accept && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (glyphs.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fgrp_pkg::PH_FILE_HDR;
            hdr_cnt_reg   <= '0;
            body_left_reg <= '0;
            glyph_blk_reg <= 1'b0;
            rec_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                body_left_reg <= body_left_next;
                glyph_blk_reg <= glyph_blk_next;
                rec_idx_reg   <= rec_idx_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && produce)
        begin
            out_reg <= glyph_unpacked;
        end
    end

    assign glyphs.valid         = out_valid_reg;
    assign glyphs.glyph_code    = out_reg.glyph_code;
    assign glyphs.atlas_x       = out_reg.atlas_x;
    assign glyphs.atlas_y       = out_reg.atlas_y;
    assign glyphs.glyph_width   = out_reg.glyph_width;
    assign glyphs.glyph_height  = out_reg.glyph_height;
    assign glyphs.draw_offset_x = out_reg.draw_offset_x;
    assign glyphs.draw_offset_y = out_reg.draw_offset_y;
    assign glyphs.advance       = out_reg.advance;
    assign glyphs.page_index    = out_reg.page_index;
    assign glyphs.channel_mask  = out_reg.channel_mask;

endmodule

### sim/tb_font_glyph_record_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_font_glyph_record_parser_unit
// streams font files byte by byte into the glyph record parser, predicts every
// glyph transaction from its own parse or a typed row and checks each field in
// order; idle, stall and long back-pressure patterns vary over the run
// ----------------------------------------------------------------------------
module tb_font_glyph_record_parser_unit;

    localparam int CLK_HALF          = 4;
    localparam int RESET_CYCLES      = 5;
    localparam int BYTES_PER_PHASE   = 660;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int DRAIN_CYCLES      = 8;
    localparam int DIR_ROWS          = 13;

    typedef struct packed {
        logic [7:0]       data;
        logic             sof;
        logic [5:0]       reps;
        logic             typed;
        fgrp_pkg::glyph_t glyph;
    } dir_row_t;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'hA5,                    1'b1, 6'd1,  1'b0, '0},   // file header on start flag
        '{8'h00,                    1'b0, 6'd3,  1'b0, '0},
        '{fgrp_pkg::GLYPH_BLOCK_ID, 1'b0, 6'd1,  1'b0, '0},   // glyph block, 21-byte body
        '{8'h15,                    1'b0, 6'd1,  1'b0, '0},
        '{8'h00,                    1'b0, 6'd3,  1'b0, '0},
        '{8'hFF,                    1'b0, 6'd20, 1'b1, '1},   // all-ones record
        '{8'h5A,                    1'b0, 6'd1,  1'b0, '0},   // partial record, dropped
        '{8'h09,                    1'b0, 6'd1,  1'b0, '0},   // empty block
        '{8'h00,                    1'b0, 6'd4,  1'b0, '0},
        '{fgrp_pkg::GLYPH_BLOCK_ID, 1'b0, 6'd1,  1'b0, '0},   // largest body size
        '{8'hFF,                    1'b0, 6'd4,  1'b0, '0},
        '{8'h3C,                    1'b0, 6'd1,  1'b0, '0},
        '{8'h00,                    1'b1, 6'd1,  1'b0, '0}    // restart inside a body
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fgrp_byte_if  bytes_if ();
    fgrp_glyph_if glyphs_if ();

    font_glyph_record_parser_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .bytes  (bytes_if),
        .glyphs (glyphs_if)
    );

    always #(CLK_HALF) clk = ~clk;

    int unsigned      send_idle_pct  = 34;
    int unsigned      recv_idle_pct  = 59;
    bit               long_stall_req = 1'b0;
    logic             offer_typed;
    fgrp_pkg::glyph_t offer_glyph;
    int unsigned      bytes_sent     = 0;
    int unsigned      fail_count     = 0;
    int unsigned      quiet_cycles   = 0;
    fgrp_pkg::glyph_t pending_glyphs [$];

    // parser state
    fgrp_pkg::phase_t fp_phase;
    logic [31:0]      fp_count;
    logic [7:0]       fp_block_id;
    logic [31:0]      fp_block_size;
    int unsigned      fp_rec_idx;
    logic [7:0]       fp_rec_bytes [fgrp_pkg::RECORD_LEN - 1];

    function automatic void font_parse_reset();
        fp_phase      = fgrp_pkg::PH_FILE_HDR;
        fp_count      = '0;
        fp_block_id   = '0;
        fp_block_size = '0;
        fp_rec_idx    = 0;
        foreach (fp_rec_bytes[i])
            fp_rec_bytes[i] = '0;
    endfunction

    function automatic void pending_add(input fgrp_pkg::glyph_t g);
        pending_glyphs.insert(pending_glyphs.size(), g);
    endfunction

    function automatic bit font_parse_byte(input logic [7:0] b, input logic sof,
                                           output fgrp_pkg::glyph_t g);
        bit got;
        got = 1'b0;
        g   = '0;
        if (sof)
            font_parse_reset();
        case (fp_phase)
            fgrp_pkg::PH_BLOCK_HDR:
            begin
                if (fp_count == 0)
                begin
                    fp_block_id   = b;
                    fp_block_size = '0;
                end
                else
                    fp_block_size = fp_block_size | ({24'd0, b} << (8 * ((fp_count - 1) % 4)));
                fp_count++;
                if (fp_count >= fgrp_pkg::BLOCK_HEADER_LEN)
                begin
                    fp_count   = '0;
                    fp_rec_idx = 0;
                    if (fp_block_size != 0)
                        fp_phase = fgrp_pkg::PH_BODY;
                end
            end
            fgrp_pkg::PH_BODY:
            begin
                if (fp_block_id == fgrp_pkg::GLYPH_BLOCK_ID)
                begin
                    if (fp_rec_idx < fgrp_pkg::RECORD_LEN - 1)
                    begin
                        fp_rec_bytes[fp_rec_idx] = b;
                        fp_rec_idx++;
                    end
                    else
                    begin
                        g.glyph_code    = {fp_rec_bytes[3], fp_rec_bytes[2],
                                           fp_rec_bytes[1], fp_rec_bytes[0]};
                        g.atlas_x       = {fp_rec_bytes[5], fp_rec_bytes[4]};
                        g.atlas_y       = {fp_rec_bytes[7], fp_rec_bytes[6]};
                        g.glyph_width   = {fp_rec_bytes[9], fp_rec_bytes[8]};
                        g.glyph_height  = {fp_rec_bytes[11], fp_rec_bytes[10]};
                        g.draw_offset_x = {fp_rec_bytes[13], fp_rec_bytes[12]};
                        g.draw_offset_y = {fp_rec_bytes[15], fp_rec_bytes[14]};
                        g.advance       = {fp_rec_bytes[17], fp_rec_bytes[16]};
                        g.page_index    = fp_rec_bytes[18];
                        g.channel_mask  = b;
                        got             = 1'b1;
                        fp_rec_idx      = 0;
                    end
                end
                fp_count++;
                if (fp_count >= fp_block_size)
                begin
                    fp_phase   = fgrp_pkg::PH_BLOCK_HDR;
                    fp_count   = '0;
                    fp_rec_idx = 0;
                end
            end
            default:
            begin
                fp_count++;
                if (fp_count >= fgrp_pkg::FILE_HEADER_LEN)
                begin
                    fp_phase = fgrp_pkg::PH_BLOCK_HDR;
                    fp_count = '0;
                end
            end
        endcase
        return got;
    endfunction

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (actv !== expv)
        begin
            $error("%s expected %0h actual %0h", name, expv, actv);
            fail_count++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic sof, input logic typed,
                             input fgrp_pkg::glyph_t tg);
        while ($urandom_range(99) < send_idle_pct)
        begin
            bytes_if.valid <= 1'b0;
            @(posedge clk);
        end
        bytes_if.valid         <= 1'b1;
        bytes_if.data_byte     <= b;
        bytes_if.start_of_file <= sof;
        offer_typed            <= typed;
        offer_glyph            <= tg;
        @(posedge clk);
        while (!bytes_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_noise(input int unsigned n, input bit with_sof);
        repeat (n)
            send_byte(8'($urandom_range(255)), with_sof && ($urandom_range(7) == 0), 1'b0, '0);
    endtask

    task automatic send_block_header(input logic [7:0] id, input logic [31:0] size);
        send_byte(id, 1'b0, 1'b0, '0);
        for (int i = 0; i < 4; i++)
            send_byte(size[8 * i +: 8], 1'b0, 1'b0, '0);
    endtask

    task automatic send_font_file();
        int unsigned kind;
        int unsigned n_rec;
        int unsigned part;
        logic [7:0]  id;
        logic [31:0] size;
        send_byte(8'($urandom_range(255)), $urandom_range(9) != 0, 1'b0, '0);
        repeat (fgrp_pkg::FILE_HEADER_LEN - 1)
            send_byte(8'($urandom_range(255)), $urandom_range(49) == 0, 1'b0, '0);
        repeat ($urandom_range(1, 4))
        begin
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                n_rec = $urandom_range(1, 4);
                part  = ($urandom_range(3) == 0) ?
                        $urandom_range(1, fgrp_pkg::RECORD_LEN - 1) : 0;
                send_block_header(fgrp_pkg::GLYPH_BLOCK_ID,
                                  n_rec * fgrp_pkg::RECORD_LEN + part);
                send_noise(n_rec * fgrp_pkg::RECORD_LEN + part, 1'b0);
            end
            else if (kind < 75)
            begin
                do
                    id = 8'($urandom_range(255));
                while (id == fgrp_pkg::GLYPH_BLOCK_ID);
                size = $urandom_range(12);
                send_block_header(id, size);
                send_noise(size, 1'b0);
            end
            else if (kind < 82)
                send_block_header(8'($urandom_range(255)), '0);
            else if (kind < 92)
            begin
                // huge body, cut short by the next start flag
                id = $urandom_range(1) ? fgrp_pkg::GLYPH_BLOCK_ID : 8'($urandom_range(255));
                send_block_header(id, $urandom);
                send_noise($urandom_range(0, 30), 1'b0);
                return;
            end
            else
            begin
                send_noise($urandom_range(1, 25), 1'b1);
                return;
            end
        end
    endtask

    task automatic wait_for_drain();
        bytes_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_glyphs.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // checks glyph transactions and predicts from accepted byte transactions
    always @(posedge clk)
    begin : scoreboard
        fgrp_pkg::glyph_t seen;
        fgrp_pkg::glyph_t want;
        fgrp_pkg::glyph_t predicted;
        bit               got;
        if (rst_n)
        begin
            if (glyphs_if.valid && glyphs_if.ready)
            begin
                seen = '{glyphs_if.glyph_code, glyphs_if.atlas_x, glyphs_if.atlas_y,
                         glyphs_if.glyph_width, glyphs_if.glyph_height,
                         glyphs_if.draw_offset_x, glyphs_if.draw_offset_y,
                         glyphs_if.advance, glyphs_if.page_index, glyphs_if.channel_mask};
                if (pending_glyphs.size() == 0)
                begin
                    $error("glyph with no pending record, glyph_code %0h", seen.glyph_code);
                    fail_count++;
                end
                else
                begin
                    want = pending_glyphs.pop_front();
                    check_field("glyph_code", want.glyph_code, seen.glyph_code);
                    check_field("atlas_x", 32'(want.atlas_x), 32'(seen.atlas_x));
                    check_field("atlas_y", 32'(want.atlas_y), 32'(seen.atlas_y));
                    check_field("glyph_width", 32'(want.glyph_width),
                                32'(seen.glyph_width));
                    check_field("glyph_height", 32'(want.glyph_height),
                                32'(seen.glyph_height));
                    check_field("draw_offset_x", 32'(want.draw_offset_x),
                                32'(seen.draw_offset_x));
                    check_field("draw_offset_y", 32'(want.draw_offset_y),
                                32'(seen.draw_offset_y));
                    check_field("advance", 32'(want.advance), 32'(seen.advance));
                    check_field("page_index", 32'(want.page_index), 32'(seen.page_index));
                    check_field("channel_mask", 32'(want.channel_mask),
                                32'(seen.channel_mask));
                end
            end
            if (bytes_if.valid && bytes_if.ready)
            begin
                got = font_parse_byte(bytes_if.data_byte, bytes_if.start_of_file, predicted);
                if (offer_typed)
                    pending_add(offer_glyph);
                else if (got)
                    pending_add(predicted);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (bytes_if.valid && bytes_if.ready) ||
            (glyphs_if.valid && glyphs_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // glyph receiver
    initial
    begin
        glyphs_if.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (long_stall_req)
            begin
                glyphs_if.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES)
                    @(posedge clk);
                long_stall_req = 1'b0;
            end
            glyphs_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // byte sender and run control
    initial
    begin
        int unsigned phase_start;
        bytes_if.valid         <= 1'b0;
        bytes_if.data_byte     <= '0;
        bytes_if.start_of_file <= 1'b0;
        offer_typed            <= 1'b0;
        offer_glyph            <= '0;
        font_parse_reset();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TABLE[r])
            for (int k = 0; k < DIR_TABLE[r].reps; k++)
                send_byte(DIR_TABLE[r].data, DIR_TABLE[r].sof,
                          DIR_TABLE[r].typed && (k == DIR_TABLE[r].reps - 1),
                          DIR_TABLE[r].glyph);
        wait_for_drain();

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 34 : (p == 1) ? 59 : 0;
            recv_idle_pct = (p == 0) ? 59 : (p == 1) ? 34 : 0;
            if (p == 2)
                long_stall_req = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE)
                send_font_file();
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending_glyphs.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
